// ===== rtl/core/name_hash_table_lookup_top_macros.svh =====
// Assertion macros for the name hash table lookup
`ifndef NAME_HASH_TABLE_LOOKUP_TOP_MACROS_SVH
`define NAME_HASH_TABLE_LOOKUP_TOP_MACROS_SVH
`ifndef SYNTHESIS
`define NHTL_ASSERT_IMP(lbl, ck, rn, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) else $error(msg);
`define NHTL_ASSERT_NXT(lbl, ck, rn, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) else $error(msg);
`else
`define NHTL_ASSERT_IMP(lbl, ck, rn, ante, cons, msg)
`define NHTL_ASSERT_NXT(lbl, ck, rn, ante, cons, msg)
`endif
`endif

// ===== rtl/core/nhtl_pkg.sv =====
`default_nettype none
package nhtl_pkg;
	localparam int TABLE_DEPTH = 64;
	localparam int IDX_W = $clog2(TABLE_DEPTH);
	localparam int CNT_W = IDX_W + 1;
	localparam int WORD_W = 32;
	localparam int BYTE_W = 8;
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

	localparam logic [WORD_W-1:0] CRC_POLY = 32'hEDB88320;
	localparam logic [WORD_W-1:0] CRC_ONES = 32'hFFFFFFFF;

	localparam logic CMD_WRITE = 1'b0;
	localparam logic CMD_NAME  = 1'b1;

	typedef struct packed {
		logic              lookup;
		logic [IDX_W-1:0]  index;
		logic [WORD_W-1:0] key;
		logic [WORD_W-1:0] offset;
		logic [WORD_W-1:0] length;
	} op_t;

	typedef struct packed {
		logic [WORD_W-1:0] key;
		logic [WORD_W-1:0] offset;
		logic [WORD_W-1:0] length;
	} entry_t;

	typedef struct packed {
		logic full;
		logic empty;
	} qstat_t;

	function automatic logic [WORD_W-1:0] crc_feed(input logic [WORD_W-1:0] crc,
		input logic [BYTE_W-1:0] data);
		logic [WORD_W-1:0] c;
		c = crc ^ {{(WORD_W-BYTE_W){1'b0}}, data};
		for (int i = 0; i < BYTE_W; i++) begin
			c = c[0] ? (CRC_POLY ^ (c >> 1)) : (c >> 1);
		end
		return c;
	endfunction
endpackage
`default_nettype wire

// ===== rtl/core/nhtl_if.sv =====
`default_nettype none
interface nhtl_in_if import nhtl_pkg::*; ();
	logic              valid;
	logic              ready;
	logic              command;
	logic [IDX_W-1:0]  write_index;
	logic [WORD_W-1:0] write_key;
	logic [WORD_W-1:0] write_offset;
	logic [WORD_W-1:0] write_length;
	logic [BYTE_W-1:0] name_byte;
	logic              last_byte;

	modport source (output valid, command, write_index, write_key, write_offset,
		write_length, name_byte, last_byte, input ready);
	modport sink (input valid, command, write_index, write_key, write_offset,
		write_length, name_byte, last_byte, output ready);
endinterface

interface nhtl_out_if import nhtl_pkg::*; ();
	logic              valid;
	logic              ready;
	logic              found;
	logic [IDX_W-1:0]  hit_index;
	logic [WORD_W-1:0] hit_offset;
	logic [WORD_W-1:0] hit_length;
	logic [WORD_W-1:0] name_hash;

	modport source (output valid, found, hit_index, hit_offset, hit_length, name_hash,
		input ready);
	modport sink (input valid, found, hit_index, hit_offset, hit_length, name_hash,
		output ready);
endinterface

interface nhtl_cfg_if import nhtl_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [CNT_W-1:0] entry_count;

	modport source (output valid, entry_count, input ready);
	modport sink (input valid, entry_count, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/nhtl_front.sv =====
`default_nettype none
module nhtl_front import nhtl_pkg::*; (
	input  wire logic  clk,
	input  wire logic  arst_n,
	nhtl_in_if.sink    items,
	input  wire qstat_t qstat,
	output logic       push,
	output op_t        push_op
);
	logic [WORD_W-1:0] crc_q;
	logic [WORD_W-1:0] crc_nx;
	logic              acc;

	assign items.ready = !qstat.full;
	assign acc = items.valid && items.ready;
	assign crc_nx = crc_feed(crc_q, items.name_byte);

	assign push = acc && ((items.command == CMD_WRITE) || items.last_byte);

	always_comb begin
		push_op.lookup = (items.command == CMD_NAME);
		push_op.index  = items.write_index;
		push_op.key    = (items.command == CMD_NAME) ? ~crc_nx : items.write_key;
		push_op.offset = items.write_offset;
		push_op.length = items.write_length;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_q <= CRC_ONES;
		end else if (acc && (items.command == CMD_NAME)) begin
			crc_q <= items.last_byte ? CRC_ONES : crc_nx;
		end
	end
endmodule
`default_nettype wire

// ===== rtl/core/nhtl_fifo.sv =====
`default_nettype none
module nhtl_fifo import nhtl_pkg::*; (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  push,
	input  wire op_t   push_op,
	input  wire logic  pop,
	output op_t        head,
	output qstat_t     qstat
);
	op_t               q_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] cnt_q;
	logic              do_push;
	logic              do_pop;

	assign qstat.full  = (cnt_q == QCNT_W'(QUEUE_DEPTH));
	assign qstat.empty = (cnt_q == '0);
	assign do_push = push && !qstat.full;
	assign do_pop  = pop && !qstat.empty;
	assign head = q_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			q_q[wr_ptr_q] <= push_op;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end
endmodule
`default_nettype wire

// ===== rtl/core/nhtl_back.sv =====
`default_nettype none
module nhtl_back import nhtl_pkg::*; (
	input  wire logic  clk,
	input  wire logic  arst_n,
	nhtl_cfg_if.sink   cfg,
	input  wire op_t   head,
	input  wire qstat_t qstat,
	output logic       pop,
	nhtl_out_if.source results
);
	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_SRCH = 2'd1;
	localparam logic [1:0] S_CMP  = 2'd2;
	localparam logic [1:0] S_OUT  = 2'd3;

	logic [1:0]        state_q;
	logic [CNT_W-1:0]  count_q;
	logic [CNT_W-1:0]  cnt_eff;
	logic [CNT_W-1:0]  lo_q;
	logic [CNT_W-1:0]  hx_q;
	logic [CNT_W:0]    sum;
	logic [IDX_W-1:0]  mid;
	logic [IDX_W-1:0]  mid_q;
	logic [WORD_W-1:0] hash_q;
	entry_t            mem [TABLE_DEPTH];
	entry_t            rd_q;
	logic              res_found_q;
	logic [IDX_W-1:0]  res_index_q;
	logic [WORD_W-1:0] res_offset_q;
	logic [WORD_W-1:0] res_length_q;
	logic              ovalid_q;
	logic              found_q;
	logic [IDX_W-1:0]  index_q;
	logic [WORD_W-1:0] offset_q;
	logic [WORD_W-1:0] length_q;
	logic [WORD_W-1:0] nhash_q;
	logic              out_free;

	assign cfg.ready = 1'b1;
	assign cnt_eff = (count_q > CNT_W'(TABLE_DEPTH)) ? CNT_W'(TABLE_DEPTH) : count_q;
	assign sum = {1'b0, lo_q} + {1'b0, hx_q} - 1'b1;
	assign mid = sum[IDX_W:1];
	assign pop = (state_q == S_IDLE) && !qstat.empty;
	assign out_free = !ovalid_q || results.ready;

	assign results.valid      = ovalid_q;
	assign results.found      = found_q;
	assign results.hit_index  = index_q;
	assign results.hit_offset = offset_q;
	assign results.hit_length = length_q;
	assign results.name_hash  = nhash_q;

	always_ff @(posedge clk) begin
		if (pop && !head.lookup) begin
			mem[head.index] <= '{key: head.key, offset: head.offset, length: head.length};
		end
		rd_q <= mem[mid];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (cfg.valid) begin
			count_q <= cfg.entry_count;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (pop && head.lookup) begin
						state_q <= S_SRCH;
					end
				end
				S_SRCH: begin
					state_q <= (lo_q < hx_q) ? S_CMP : S_OUT;
				end
				S_CMP: begin
					state_q <= (rd_q.key == hash_q) ? S_OUT : S_SRCH;
				end
				S_OUT: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (pop && head.lookup) begin
					hash_q <= head.key;
					lo_q   <= '0;
					hx_q   <= cnt_eff;
				end
			end
			S_SRCH: begin
				mid_q <= mid;
				if (!(lo_q < hx_q)) begin
					res_found_q  <= 1'b0;
					res_index_q  <= '0;
					res_offset_q <= '0;
					res_length_q <= '0;
				end
			end
			S_CMP: begin
				if (rd_q.key == hash_q) begin
					res_found_q  <= 1'b1;
					res_index_q  <= mid_q;
					res_offset_q <= rd_q.offset;
					res_length_q <= rd_q.length;
				end else if (rd_q.key < hash_q) begin
					lo_q <= {1'b0, mid_q} + 1'b1;
				end else begin
					hx_q <= {1'b0, mid_q};
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ovalid_q <= 1'b0;
		end else if ((state_q == S_OUT) && out_free) begin
			ovalid_q <= 1'b1;
		end else if (results.ready) begin
			ovalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == S_OUT) && out_free) begin
			found_q  <= res_found_q;
			index_q  <= res_index_q;
			offset_q <= res_offset_q;
			length_q <= res_length_q;
			nhash_q  <= hash_q;
		end
	end
endmodule
`default_nettype wire

// ===== rtl/core/name_hash_table_lookup_top.sv =====
// Channel  Side  Handshake    Payload
// items    in    valid/ready  command, write_index, write_key, write_offset,
//                             write_length, name_byte, last_byte
// results  out   valid/ready  found, hit_index, hit_offset, hit_length, name_hash
// cfg      in    valid/ready  entry_count (ready always high)
//
// Name bytes and table writes enter one a cycle while the two-item queue has room;
// the CRC step for a byte completes in the cycle it is taken.
// A table write is stored in the back part as it leaves the queue; a lookup makes each
// bisection probe in S_SRCH (table read) and S_CMP (key compare), at most 7 probes for
// 64 entries, then moves to S_OUT, which loads the output register once it is free.
// Reset clears the CRC to all ones, entry_count to 0, the queue and the sequencer;
// table contents stay undefined until written.
// A stalled result holds the back part; the queue then fills and items.ready falls.
`default_nettype none
`include "name_hash_table_lookup_top_macros.svh"
module name_hash_table_lookup_top import nhtl_pkg::*; (
	input  wire logic  clk,
	input  wire logic  arst_n,
	nhtl_in_if.sink    items,
	nhtl_out_if.source results,
	nhtl_cfg_if.sink   cfg
);
	qstat_t qstat;
	logic   push;
	op_t    push_op;
	logic   pop;
	op_t    head;

	nhtl_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.items   (items),
		.qstat   (qstat),
		.push    (push),
		.push_op (push_op)
	);

	nhtl_fifo u_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.push_op (push_op),
		.pop     (pop),
		.head    (head),
		.qstat   (qstat)
	);

	nhtl_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg),
		.head    (head),
		.qstat   (qstat),
		.pop     (pop),
		.results (results)
	);

	`NHTL_ASSERT_IMP(a_no_push_full, clk, arst_n, push, !qstat.full, "item pushed into full queue")
	`NHTL_ASSERT_IMP(a_qstat_sane, clk, arst_n, qstat.full, !qstat.empty, "queue full and empty")
	`NHTL_ASSERT_NXT(a_push_fills, clk, arst_n, push && qstat.empty, !qstat.empty, "item lost")
	`NHTL_ASSERT_IMP(a_miss_zero, clk, arst_n, results.valid && !results.found, (results.hit_index == '0) && (results.hit_offset == '0) && (results.hit_length == '0), "miss with non-zero entry fields")
endmodule
`default_nettype wire

// ===== sim/testbench.sv =====
`timescale 1ns / 100ps
module testbench;
	import nhtl_pkg::*;

	typedef struct packed {
		logic              command;
		logic [IDX_W-1:0]  write_index;
		logic [WORD_W-1:0] write_key;
		logic [WORD_W-1:0] write_offset;
		logic [WORD_W-1:0] write_length;
		logic [BYTE_W-1:0] name_byte;
		logic              last_byte;
	} lookup_item_t;

	typedef struct packed {
		logic              found;
		logic [IDX_W-1:0]  hit_index;
		logic [WORD_W-1:0] hit_offset;
		logic [WORD_W-1:0] hit_length;
		logic [WORD_W-1:0] name_hash;
	} lookup_result_t;

	localparam int SETTLE_CYCLES = 24;
	localparam int PHASE_ITEMS   = 140;

	function automatic logic [WORD_W-1:0] crc_after_byte(input logic [WORD_W-1:0] crc,
		input logic [BYTE_W-1:0] data);
		logic [WORD_W-1:0] acc;
		acc = crc ^ {24'd0, data};
		for (int b = 0; b < BYTE_W; b++) begin
			if (acc[0])
				acc = (acc >> 1) ^ CRC_POLY;
			else
				acc = acc >> 1;
		end
		return acc;
	endfunction

	function automatic logic [WORD_W-1:0] name_hash_of(input logic [63:0] data, input int len);
		logic [WORD_W-1:0] acc;
		acc = CRC_ONES;
		for (int i = 0; i < len; i++)
			acc = crc_after_byte(acc, data[8*i +: 8]);
		return ~acc;
	endfunction

	class lookup_scoreboard;
		logic [WORD_W-1:0] key_copy[TABLE_DEPTH];
		logic [WORD_W-1:0] offset_copy[TABLE_DEPTH];
		logic [WORD_W-1:0] length_copy[TABLE_DEPTH];
		logic [WORD_W-1:0] crc_acc;
		int                searched;
		lookup_result_t    awaited[$];
		int                mismatches;

		function new();
			crc_acc = CRC_ONES;
			searched = 0;
			mismatches = 0;
		endfunction

		function void set_count(input logic [CNT_W-1:0] value);
			searched = value;
		endfunction

		function int pending();
			return awaited.size();
		endfunction

		function void apply_item(input lookup_item_t it);
			lookup_result_t    r;
			logic [WORD_W-1:0] h;
			int                lo, hi, mid, n;
			if (it.command == CMD_WRITE) begin
				key_copy[it.write_index] = it.write_key;
				offset_copy[it.write_index] = it.write_offset;
				length_copy[it.write_index] = it.write_length;
				return;
			end
			crc_acc = crc_after_byte(crc_acc, it.name_byte);
			if (!it.last_byte)
				return;
			h = ~crc_acc;
			crc_acc = CRC_ONES;
			n = (searched > TABLE_DEPTH) ? TABLE_DEPTH : searched;
			r = '0;
			r.name_hash = h;
			lo = 0;
			hi = n - 1;
			while (lo <= hi) begin
				mid = (lo + hi) / 2;
				if (key_copy[mid] == h) begin
					r.found = 1'b1;
					r.hit_index = IDX_W'(mid);
					r.hit_offset = offset_copy[mid];
					r.hit_length = length_copy[mid];
					break;
				end else if (key_copy[mid] < h) begin
					lo = mid + 1;
				end else begin
					hi = mid - 1;
				end
			end
			awaited.push_back(r);
		endfunction

		task report_mismatch(input string msg);
			if (mismatches < 100)
				$display("%0t: mismatch: %s", $time, msg);
			mismatches++;
		endtask

		task check_lookup(input lookup_result_t got);
			lookup_result_t want;
			if (awaited.size() == 0) begin
				report_mismatch($sformatf("result with no lookup pending, hash %h", got.name_hash));
				return;
			end
			want = awaited.pop_front();
			if (got.found !== want.found)
				report_mismatch($sformatf("found %0b, want %0b (hash %h)",
					got.found, want.found, want.name_hash));
			if (got.hit_index !== want.hit_index)
				report_mismatch($sformatf("hit_index %0d, want %0d (hash %h)",
					got.hit_index, want.hit_index, want.name_hash));
			if (got.hit_offset !== want.hit_offset)
				report_mismatch($sformatf("hit_offset %h, want %h (hash %h)",
					got.hit_offset, want.hit_offset, want.name_hash));
			if (got.hit_length !== want.hit_length)
				report_mismatch($sformatf("hit_length %h, want %h (hash %h)",
					got.hit_length, want.hit_length, want.name_hash));
			if (got.name_hash !== want.name_hash)
				report_mismatch($sformatf("name_hash %h, want %h",
					got.name_hash, want.name_hash));
		endtask

		task flush_leftovers();
			while (awaited.size() != 0) begin
				report_mismatch($sformatf("no result for hash %h", awaited[0].name_hash));
				void'(awaited.pop_front());
			end
		endtask
	endclass

	logic clk = 1'b0;
	logic arst_n;

	nhtl_in_if  items();
	nhtl_out_if results();
	nhtl_cfg_if cfg();

	name_hash_table_lookup_top DUT (
		.clk(clk),
		.arst_n(arst_n),
		.items(items),
		.results(results),
		.cfg(cfg)
	);

	always #6 clk = ~clk;

	lookup_scoreboard  sb;
	lookup_result_t    observed;
	int                send_idle_pct;
	int                recv_stall_pct;
	int                items_sent;
	logic [63:0]       tab_name[TABLE_DEPTH];
	int                tab_name_len[TABLE_DEPTH];
	logic [WORD_W-1:0] tab_key[TABLE_DEPTH];

	always @(negedge clk)
		results.ready <= ($urandom_range(99) >= recv_stall_pct);

	always @(posedge clk) begin
		if (arst_n && results.valid && results.ready) begin
			observed.found = results.found;
			observed.hit_index = results.hit_index;
			observed.hit_offset = results.hit_offset;
			observed.hit_length = results.hit_length;
			observed.name_hash = results.name_hash;
			sb.check_lookup(observed);
		end
	end

	function automatic lookup_item_t random_item();
		lookup_item_t it;
		it.command = $urandom_range(1);
		it.write_index = $urandom_range(TABLE_DEPTH - 1);
		it.write_key = $urandom;
		it.write_offset = $urandom;
		it.write_length = $urandom;
		it.name_byte = $urandom_range(255);
		it.last_byte = $urandom_range(1);
		return it;
	endfunction

	task automatic send_item(input lookup_item_t it);
		while ($urandom_range(99) < send_idle_pct) begin
			items.valid <= 1'b0;
			@(negedge clk);
		end
		items.valid <= 1'b1;
		items.command <= it.command;
		items.write_index <= it.write_index;
		items.write_key <= it.write_key;
		items.write_offset <= it.write_offset;
		items.write_length <= it.write_length;
		items.name_byte <= it.name_byte;
		items.last_byte <= it.last_byte;
		@(posedge clk);
		while (!items.ready)
			@(posedge clk);
		sb.apply_item(it);
		items_sent++;
		@(negedge clk);
	endtask

	task automatic send_write(input int slot, input logic [WORD_W-1:0] key,
		input logic [WORD_W-1:0] offset, input logic [WORD_W-1:0] length);
		lookup_item_t it;
		it = random_item();
		it.command = CMD_WRITE;
		it.write_index = IDX_W'(slot);
		it.write_key = key;
		it.write_offset = offset;
		it.write_length = length;
		tab_key[slot] = key;
		send_item(it);
	endtask

	// rewrite a slot with its own key: order is kept
	task automatic refresh_entry();
		int slot;
		slot = $urandom_range(TABLE_DEPTH - 1);
		send_write(slot, tab_key[slot], $urandom, $urandom);
	endtask

	task automatic send_name(input logic [63:0] data, input int len, input int write_pct);
		lookup_item_t it;
		for (int i = 0; i < len; i++) begin
			if (i != 0 && $urandom_range(99) < write_pct)
				refresh_entry();
			it = random_item();
			it.command = CMD_NAME;
			it.name_byte = data[8*i +: 8];
			it.last_byte = (i == len - 1);
			send_item(it);
		end
	endtask

	task automatic refill_table();
		logic [63:0]       nm;
		logic [WORD_W-1:0] k;
		int                ln, j, first;
		for (int i = 0; i < TABLE_DEPTH; i++) begin
			tab_name_len[i] = $urandom_range(1, 8);
			tab_name[i] = {$urandom, $urandom};
			tab_key[i] = name_hash_of(tab_name[i], tab_name_len[i]);
		end
		for (int i = 1; i < TABLE_DEPTH; i++) begin
			nm = tab_name[i];
			k = tab_key[i];
			ln = tab_name_len[i];
			j = i - 1;
			while (j >= 0 && tab_key[j] > k) begin
				tab_name[j+1] = tab_name[j];
				tab_key[j+1] = tab_key[j];
				tab_name_len[j+1] = tab_name_len[j];
				j--;
			end
			tab_name[j+1] = nm;
			tab_key[j+1] = k;
			tab_name_len[j+1] = ln;
		end
		first = $urandom_range(TABLE_DEPTH - 1);
		for (int i = 0; i < TABLE_DEPTH; i++) begin
			j = (first + i) % TABLE_DEPTH;
			if (j == 0)
				send_write(j, tab_key[j], '0, '0);
			else if (j == TABLE_DEPTH - 1)
				send_write(j, tab_key[j], '1, '1);
			else
				send_write(j, tab_key[j], $urandom, $urandom);
		end
	endtask

	task automatic wait_results_done();
		items.valid <= 1'b0;
		while (sb.pending() != 0)
			@(negedge clk);
	endtask

	task automatic settle_and_program(input logic [CNT_W-1:0] value);
		wait_results_done();
		repeat (SETTLE_CYCLES) @(negedge clk);
		cfg.valid <= 1'b1;
		cfg.entry_count <= value;
		@(posedge clk);
		while (!cfg.ready)
			@(posedge clk);
		sb.set_count(value);
		@(negedge clk);
		cfg.valid <= 1'b0;
	endtask

	task automatic random_op(input int count);
		int eff, slot, pick, len;
		eff = (count > TABLE_DEPTH) ? TABLE_DEPTH : count;
		pick = $urandom_range(99);
		slot = (eff > 0 && $urandom_range(99) < 80) ? $urandom_range(eff - 1)
			: $urandom_range(TABLE_DEPTH - 1);
		len = $urandom_range(1, 8);
		if (pick < 55 && tab_name_len[slot] > 0) begin
			send_name(tab_name[slot], tab_name_len[slot], 8);
		end else if (pick < 80) begin
			send_name({$urandom, $urandom}, len, 8);
		end else if (pick < 85) begin
			send_name('0, len, 0);
		end else if (pick < 95) begin
			refresh_entry();
		end else begin
			// random key: may break the ordering
			tab_name_len[slot] = 0;
			send_write(slot, $urandom, $urandom, $urandom);
		end
	endtask

	int             idle_plan[4]  = '{0, 82, 0, 21};
	int             stall_plan[4] = '{0, 0, 82, 21};
	logic [CNT_W-1:0] count_plan[4];

	initial begin
		lookup_item_t     it;
		logic [63:0]      nm;
		logic [WORD_W-1:0] k;
		int               ln, start;
		bit               paused;
		sb = new();
		items.valid = 1'b0;
		items.command = CMD_WRITE;
		items.write_index = '0;
		items.write_key = '0;
		items.write_offset = '0;
		items.write_length = '0;
		items.name_byte = '0;
		items.last_byte = 1'b0;
		cfg.valid = 1'b0;
		cfg.entry_count = '0;
		results.ready = 1'b0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		items_sent = 0;
		arst_n = 1'b0;
		repeat (2) @(negedge clk);
		arst_n = 1'b1;

		// empty table, zero byte, byte extremes
		settle_and_program('0);
		send_name(64'h0, 1, 0);
		send_name(64'h41_00_FF, 3, 0);
		send_write(TABLE_DEPTH - 1, '1, '1, '1);
		send_write(0, '0, '0, '0);

		refill_table();
		settle_and_program(CNT_W'(TABLE_DEPTH));
		send_name(tab_name[0], tab_name_len[0], 0);
		send_name(tab_name[TABLE_DEPTH-1], tab_name_len[TABLE_DEPTH-1], 0);
		send_name(tab_name[31], tab_name_len[31], 0);
		send_name({$urandom, $urandom}, 5, 0);

		// table write between bytes of one name
		it = random_item();
		it.command = CMD_NAME;
		it.last_byte = 1'b0;
		send_item(it);
		refresh_entry();
		it = random_item();
		it.command = CMD_NAME;
		it.last_byte = 1'b1;
		send_item(it);

		// duplicate keys
		tab_name[10] = tab_name[11];
		tab_name_len[10] = tab_name_len[11];
		send_write(10, tab_key[11], $urandom, $urandom);
		send_name(tab_name[11], tab_name_len[11], 0);

		// unsorted table
		nm = tab_name[5];
		k = tab_key[5];
		ln = tab_name_len[5];
		tab_name[5] = tab_name[50];
		tab_name_len[5] = tab_name_len[50];
		tab_name[50] = nm;
		tab_name_len[50] = ln;
		send_write(5, tab_key[50], $urandom, $urandom);
		send_write(50, k, $urandom, $urandom);
		send_name(tab_name[5], tab_name_len[5], 0);
		send_name(tab_name[50], tab_name_len[50], 0);

		settle_and_program(CNT_W'(1));
		send_name(tab_name[0], tab_name_len[0], 0);
		send_name(tab_name[1], tab_name_len[1], 0);

		// count beyond the table
		settle_and_program('1);
		send_name(tab_name[TABLE_DEPTH-1], tab_name_len[TABLE_DEPTH-1], 0);

		count_plan[0] = CNT_W'(TABLE_DEPTH);
		count_plan[1] = '1;
		count_plan[2] = CNT_W'(33);
		count_plan[3] = CNT_W'($urandom_range(127));
		for (int p = 0; p < 4; p++) begin
			send_idle_pct = idle_plan[p];
			recv_stall_pct = stall_plan[p];
			refill_table();
			settle_and_program(count_plan[p]);
			start = items_sent;
			paused = 1'b0;
			while (items_sent - start < PHASE_ITEMS) begin
				if (!paused && items_sent - start >= PHASE_ITEMS / 2) begin
					wait_results_done();
					paused = 1'b1;
				end
				random_op(count_plan[p]);
			end
		end

		wait_results_done();
		repeat (SETTLE_CYCLES) @(negedge clk);
		sb.flush_leftovers();
		if (sb.mismatches == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

	initial begin
		#20_000_000;
		$display("Simulation FAILED");
		$finish;
	end
endmodule
